// ----- rtl/crsq_pkg.sv -----
// Shared constants, types and helpers of the character range set query block.
package crsq_pkg;

  localparam int MAX_RANGES  = 256;
  localparam int TABLE_DEPTH = 2 * MAX_RANGES;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int PAIR_W      = $clog2(MAX_RANGES + 1);
  localparam int CODE_W      = 21;
  localparam int SLOT_W      = 9;
  localparam int COUNT_W     = 9;
  localparam int ACC_W       = 32;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 3;
  localparam int REG_W       = ADDR_W - 2;
  localparam int DEF_N       = 4;

  typedef logic [CODE_W-1:0]        code_t;
  typedef logic [CODE_W:0]          key_t;
  typedef logic signed [CODE_W:0]   sz_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [IDX_W:0]           idx1_t;
  typedef logic [PAIR_W-1:0]        pair_t;
  typedef logic [COUNT_W-1:0]       count_t;
  typedef logic [REG_W-1:0]         reg_t;
  typedef logic [$clog2(DEF_N)-1:0] def_idx_t;

  localparam code_t  CODE_MAX        = '1;
  localparam count_t RANGE_COUNT_RST = count_t'(2);
  localparam reg_t   REG_RANGE_COUNT = reg_t'(0);
  localparam logic   MODE_LOAD       = 1'b0;
  localparam logic   MODE_QUERY      = 1'b1;

  localparam code_t DEFAULT_MAP [DEF_N] = '{
    code_t'('h0020), code_t'('hD800), code_t'('hE000), code_t'('hFFF0)
  };

  // Token that walks down the cell row: a boundary load or a query with its sums.
  typedef struct packed {
    logic  is_q;
    idx_t  lslot;
    code_t lval;
    code_t c;
    acc_t  k;
    acc_t  racc;
    logic  rdone;
    logic  rfound;
    code_t rank;
    logic  adone;
    code_t at;
    acc_t  total;
    acc_t  cacc;
    pair_t pmin;
    pair_t pmax;
  } tok_t;

  function automatic acc_t to_acc(code_t v);
    return acc_t'({1'b0, v});
  endfunction

  // Clamp a signed sum into the code range.
  function automatic code_t sat_code(acc_t v);
    code_t r;
    if (v < 0) begin
      r = '0;
    end else if (v > to_acc(CODE_MAX)) begin
      r = CODE_MAX;
    end else begin
      r = v[CODE_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/crsq_if.sv -----
// Item and result channel interfaces of the character range set query block.
interface crsq_in_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [crsq_pkg::SLOT_W-1:0]   slot;
  logic [crsq_pkg::CODE_W-1:0]   boundary_value;
  logic [crsq_pkg::CODE_W-1:0]   query_char;
  logic [crsq_pkg::CODE_W-1:0]   range_high;
  logic [crsq_pkg::CODE_W-1:0]   rank_in;

  modport source (
    output valid, mode, slot, boundary_value, query_char, range_high, rank_in,
    input  ready
  );
  modport sink (
    input  valid, mode, slot, boundary_value, query_char, range_high, rank_in,
    output ready
  );
endinterface

interface crsq_out_if;
  logic                          valid;
  logic                          ready;
  logic                          present;
  logic [crsq_pkg::CODE_W-1:0]   next_char;
  logic [crsq_pkg::CODE_W-1:0]   prev_char;
  logic                          rank_found;
  logic [crsq_pkg::CODE_W-1:0]   rank_of_char;
  logic [crsq_pkg::CODE_W-1:0]   char_at_rank;
  logic [crsq_pkg::CODE_W-1:0]   count_in_range;
  logic [crsq_pkg::CODE_W-1:0]   total_count;

  modport source (
    output valid, present, next_char, prev_char, rank_found, rank_of_char,
           char_at_rank, count_in_range, total_count,
    input  ready
  );
  modport sink (
    input  valid, present, next_char, prev_char, rank_found, rank_of_char,
           char_at_rank, count_in_range, total_count,
    output ready
  );
endinterface

// ----- rtl/crsq_ram.sv -----
// Generic simple dual-port RAM with registered read.
module crsq_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 512,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/crsq_cell.sv -----
// One cell of the row: holds a boundary pair and folds it into a passing query.
module crsq_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  crsq_pkg::pair_t        idx,
  input  crsq_pkg::pair_t        n,
  input  logic                   tin_vld,
  input  crsq_pkg::tok_t         tin,
  output logic                   tout_vld,
  output crsq_pkg::tok_t         tout
);

  crsq_pkg::code_t f;
  crsq_pkg::code_t l;
  crsq_pkg::sz_t   sz;
  crsq_pkg::acc_t  sz_a;
  crsq_pkg::acc_t  c_a;
  crsq_pkg::acc_t  f_a;
  crsq_pkg::tok_t  tnext;
  logic            hit;

  assign hit = tin_vld && !tin.is_q && (crsq_pkg::pair_t'(tin.lslot >> 1) == idx);

  // Keep the pair size next to the pair so the query path does not recompute it.
  always_ff @(posedge clk) begin
    if (hit) begin
      if (tin.lslot[0]) begin
        l  <= tin.lval;
        sz <= $signed({1'b0, tin.lval}) - $signed({1'b0, f});
      end else begin
        f  <= tin.lval;
        sz <= $signed({1'b0, l}) - $signed({1'b0, tin.lval});
      end
    end
    tout <= tnext;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tout_vld <= 1'b0;
    end else begin
      tout_vld <= tin_vld;
    end
  end

  always_comb begin
    sz_a  = crsq_pkg::acc_t'(sz);
    c_a   = crsq_pkg::to_acc(tin.c);
    f_a   = crsq_pkg::to_acc(f);
    tnext = tin;
    if (tin.is_q && idx < n) begin
      // rank of the query code
      if (!tin.rdone) begin
        if (tin.c >= l) begin
          tnext.racc = tin.racc + sz_a;
        end else if (tin.c >= f) begin
          tnext.rfound = 1'b1;
          tnext.rank   = crsq_pkg::sat_code(tin.racc + c_a - f_a);
          tnext.rdone  = 1'b1;
        end else begin
          tnext.rdone = 1'b1;
        end
      end
      // code at rank: stop where the remaining rank falls inside this pair
      if (!tin.adone) begin
        if (tin.k < sz_a) begin
          tnext.at    = crsq_pkg::sat_code(tin.k + f_a);
          tnext.adone = 1'b1;
        end else begin
          tnext.k = tin.k - sz_a;
        end
      end
      tnext.total = tin.total + sz_a;
      if (idx >= tin.pmin && idx <= tin.pmax) begin
        tnext.cacc = tin.cacc + sz_a;
      end
    end
  end

endmodule

// ----- rtl/crsq_chain.sv -----
// Row of boundary pair cells; a token advances one cell per cycle.
module crsq_chain (
  input  logic                clk,
  input  logic                rst,
  input  crsq_pkg::pair_t     n,
  input  logic                in_vld,
  input  crsq_pkg::tok_t      in_tok,
  output logic                out_vld,
  output crsq_pkg::tok_t      out_tok
);

  logic           vld [crsq_pkg::MAX_RANGES+1];
  crsq_pkg::tok_t tok [crsq_pkg::MAX_RANGES+1];

  assign vld[0] = in_vld;
  assign tok[0] = in_tok;

  for (genvar i = 0; i < crsq_pkg::MAX_RANGES; i++) begin : g_cell
    crsq_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .idx      (crsq_pkg::pair_t'(i)),
      .n        (n),
      .tin_vld  (vld[i]),
      .tin      (tok[i]),
      .tout_vld (vld[i+1]),
      .tout     (tok[i+1])
    );
  end

  assign out_vld = vld[crsq_pkg::MAX_RANGES];
  assign out_tok = tok[crsq_pkg::MAX_RANGES];

endmodule

// ----- rtl/char_range_set_query.sv -----
// Top level of the character range set query block: sequencer, table memory, cell row.
//
//   channel | side | carries
//   item    | in   | mode, slot, boundary_value, query_char, range_high, rank_in
//   result  | out  | present, next/prev_char, rank_found, rank_of_char, char_at_rank, counts
//   apb     | in   | range_count at byte address 0
//
// On a load the table memory is written as the item is taken and the boundary then travels
// down the cell row to its pair. A query runs from acceptance to a valid result for n pairs
// in use as four binary searches and six reads on the one table memory read port, then one
// pass of the query token through all MAX_RANGES cells.
// After reset the default map is written into the first four entries; no item is taken
// meanwhile. A finished result waits in the output register while new items are taken; a
// second query result waits in the sequencer until the first one is taken.
module char_range_set_query (
  input  logic                          clk,
  input  logic                          rst,
  crsq_in_if.sink                       item,
  crsq_out_if.source                    result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [crsq_pkg::ADDR_W-1:0]   paddr,
  input  logic [crsq_pkg::DATA_W-1:0]   pwdata,
  output logic [crsq_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_ISSUE, S_WAIT, S_CALC, S_CHAIN, S_DONE
  } state_t;

  typedef enum logic [3:0] {
    PH_FIRST, PH_LAST, PH_SA, PH_SB, PH_SC, PH_SD, PH_NB, PH_PB, PH_BMIN, PH_BMAX
  } phase_t;

  state_t             state;
  phase_t             phase;
  phase_t             phase_next;
  crsq_pkg::def_idx_t init_cnt;
  crsq_pkg::count_t   range_count;
  crsq_pkg::reg_t     reg_idx;
  crsq_pkg::pair_t    n;
  crsq_pkg::idx_t     twon_m1;

  crsq_pkg::code_t    qchar;
  crsq_pkg::code_t    qhigh;
  crsq_pkg::code_t    qrank;
  crsq_pkg::idx_t     lo;
  crsq_pkg::idx_t     hi;
  crsq_pkg::idx_t     mid;
  crsq_pkg::idx_t     lo_n;
  crsq_pkg::idx_t     hi_n;
  crsq_pkg::idx_t     mid_n;
  crsq_pkg::key_t     key;
  logic               srch;
  crsq_pkg::idx_t     ra;
  crsq_pkg::idx_t     rb;
  crsq_pkg::idx_t     rc;
  crsq_pkg::idx_t     rd;
  crsq_pkg::code_t    first_b;
  crsq_pkg::code_t    last_b;
  crsq_pkg::code_t    nb;
  crsq_pkg::code_t    pb;
  crsq_pkg::code_t    bmin;
  crsq_pkg::code_t    bmax;

  logic               ram_we;
  crsq_pkg::idx_t     ram_raddr;
  crsq_pkg::code_t    ram_rdata;
  logic               slot_ok;

  crsq_pkg::tok_t     ld_tok;
  crsq_pkg::tok_t     q_tok;
  crsq_pkg::tok_t     inj_tok;
  logic               inj_vld;
  crsq_pkg::tok_t     ch_tok;
  logic               ch_vld;
  crsq_pkg::tok_t     done_tok;

  logic               pres_c;
  crsq_pkg::code_t    next_c;
  crsq_pkg::code_t    prev_c;
  logic               pres;
  crsq_pkg::code_t    nxt;
  crsq_pkg::code_t    prv;
  crsq_pkg::acc_t     c_a;
  crsq_pkg::acc_t     first_a;
  crsq_pkg::acc_t     last_a;
  crsq_pkg::acc_t     corr1;
  crsq_pkg::acc_t     corr2;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[crsq_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      range_count <= crsq_pkg::RANGE_COUNT_RST;
    end else if (psel && penable && pwrite && reg_idx == crsq_pkg::REG_RANGE_COUNT) begin
      range_count <= pwdata[crsq_pkg::COUNT_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      crsq_pkg::REG_RANGE_COUNT: prdata = crsq_pkg::DATA_W'(range_count);
      default:                   prdata = '0;
    endcase
  end

  // Pairs in use, clamped to at least one and at most the table.
  always_comb begin
    if (range_count == '0) begin
      n = crsq_pkg::pair_t'(1);
    end else if (32'(range_count) > crsq_pkg::MAX_RANGES) begin
      n = crsq_pkg::pair_t'(crsq_pkg::MAX_RANGES);
    end else begin
      n = crsq_pkg::pair_t'(range_count);
    end
  end

  assign twon_m1 = crsq_pkg::idx_t'({n, 1'b0} - 1'b1);

  // ---------------- table memory ----------------
  assign slot_ok     = 32'(item.slot) < crsq_pkg::TABLE_DEPTH;
  assign item.ready  = (state == S_IDLE);
  assign ram_we      = (state == S_INIT) ||
                       (state == S_IDLE && item.valid && item.mode == crsq_pkg::MODE_LOAD &&
                        slot_ok);

  always_comb begin
    ld_tok      = '0;
    ld_tok.is_q = 1'b0;
    if (state == S_INIT) begin
      ld_tok.lslot = crsq_pkg::idx_t'(init_cnt);
      ld_tok.lval  = crsq_pkg::DEFAULT_MAP[init_cnt];
    end else begin
      ld_tok.lslot = crsq_pkg::idx_t'(item.slot);
      ld_tok.lval  = item.boundary_value;
    end
  end

  crsq_ram #(
    .WIDTH (crsq_pkg::CODE_W),
    .DEPTH (crsq_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ld_tok.lslot),
    .wdata (ld_tok.lval),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------- search and read steps ----------------
  always_comb begin
    case (phase)
      PH_FIRST: ram_raddr = '0;
      PH_LAST:  ram_raddr = twon_m1;
      PH_NB:    ram_raddr = rb + crsq_pkg::idx_t'(1);
      PH_PB:    ram_raddr = rc;
      PH_BMIN:  ram_raddr = ra;
      PH_BMAX:  ram_raddr = rd + crsq_pkg::idx_t'(1);
      default:  ram_raddr = mid;
    endcase

    case (phase)
      PH_SB:   key = {1'b0, qchar} + crsq_pkg::key_t'(1);
      PH_SC:   key = {1'b0, qchar} - crsq_pkg::key_t'(1);
      PH_SD:   key = {1'b0, qhigh};
      default: key = {1'b0, qchar};
    endcase

    srch = (phase == PH_SA) || (phase == PH_SB) || (phase == PH_SC) || (phase == PH_SD);

    if (key >= {1'b0, ram_rdata}) begin
      lo_n = mid;
      hi_n = hi;
    end else begin
      lo_n = lo;
      hi_n = mid - crsq_pkg::idx_t'(1);
    end
    mid_n = crsq_pkg::idx_t'((crsq_pkg::idx1_t'(lo_n) + crsq_pkg::idx1_t'(hi_n) +
                              crsq_pkg::idx1_t'(1)) >> 1);

    case (phase)
      PH_FIRST: phase_next = PH_LAST;
      PH_LAST:  phase_next = PH_SA;
      PH_SA:    phase_next = PH_SB;
      PH_SB:    phase_next = PH_SC;
      PH_SC:    phase_next = PH_SD;
      PH_SD:    phase_next = PH_NB;
      PH_NB:    phase_next = PH_PB;
      PH_PB:    phase_next = PH_BMIN;
      PH_BMIN:  phase_next = PH_BMAX;
      default:  phase_next = PH_FIRST;
    endcase
  end

  // ---------------- answers from the searches ----------------
  always_comb begin
    c_a     = crsq_pkg::to_acc(qchar);
    first_a = crsq_pkg::to_acc(first_b);
    last_a  = crsq_pkg::to_acc(last_b) - 1;

    pres_c = (ra == '0 && c_a < first_a) ? 1'b0 : !ra[0];

    if (c_a < first_a) begin
      next_c = first_b;
    end else if (c_a >= last_a) begin
      next_c = crsq_pkg::sat_code(last_a);
    end else if (rb[0]) begin
      next_c = (rb != twon_m1) ? nb : crsq_pkg::sat_code(last_a);
    end else begin
      next_c = crsq_pkg::sat_code(c_a + 1);
    end

    if (c_a <= first_a) begin
      prev_c = first_b;
    end else if (c_a > last_a) begin
      prev_c = crsq_pkg::sat_code(last_a);
    end else if (rc[0]) begin
      prev_c = crsq_pkg::sat_code(crsq_pkg::to_acc(pb) - 1);
    end else begin
      prev_c = crsq_pkg::sat_code(c_a - 1);
    end

    // trim the partial pairs at both ends of the counted range
    corr1 = (!ra[0] && c_a > crsq_pkg::to_acc(bmin)) ? c_a - crsq_pkg::to_acc(bmin) : '0;
    corr2 = (!rd[0]) ? crsq_pkg::to_acc(bmax) - crsq_pkg::to_acc(qhigh) - 1 : '0;

    q_tok      = '0;
    q_tok.is_q = 1'b1;
    q_tok.c    = qchar;
    q_tok.k    = crsq_pkg::to_acc(qrank);
    q_tok.at   = first_b;
    q_tok.cacc = -corr1 - corr2;
    q_tok.pmin = crsq_pkg::pair_t'((crsq_pkg::idx1_t'(ra) + crsq_pkg::idx1_t'(1)) >> 1);
    q_tok.pmax = crsq_pkg::pair_t'(rd >> 1);
  end

  // ---------------- cell row ----------------
  crsq_chain u_chain (
    .clk     (clk),
    .rst     (rst),
    .n       (n),
    .in_vld  (inj_vld),
    .in_tok  (inj_tok),
    .out_vld (ch_vld),
    .out_tok (ch_tok)
  );

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      phase        <= PH_FIRST;
      init_cnt     <= '0;
      inj_vld      <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      // inject every table write and each finished search into the row
      inj_vld      <= ram_we || (state == S_CALC);
      result.valid <= (state == S_DONE) || (result.valid && !result.ready);
      unique case (state)
        S_INIT: begin
          inj_tok  <= ld_tok;
          init_cnt <= init_cnt + 1'b1;
          if (init_cnt == crsq_pkg::def_idx_t'(crsq_pkg::DEF_N - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (item.valid) begin
            if (item.mode == crsq_pkg::MODE_QUERY) begin
              qchar <= item.query_char;
              qhigh <= item.range_high;
              qrank <= item.rank_in;
              phase <= PH_FIRST;
              state <= S_ISSUE;
            end else if (slot_ok) begin
              inj_tok <= ld_tok;
            end
          end
        end
        S_ISSUE: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (srch && lo_n < hi_n) begin
            lo    <= lo_n;
            hi    <= hi_n;
            mid   <= mid_n;
            state <= S_ISSUE;
          end else begin
            case (phase)
              PH_FIRST: first_b <= ram_rdata;
              PH_LAST:  last_b  <= ram_rdata;
              PH_SA:    ra      <= mid_n;
              PH_SB:    rb      <= mid_n;
              PH_SC:    rc      <= mid_n;
              PH_SD:    rd      <= mid_n;
              PH_NB:    nb      <= ram_rdata;
              PH_PB:    pb      <= ram_rdata;
              PH_BMIN:  bmin    <= ram_rdata;
              default:  bmax    <= ram_rdata;
            endcase
            // start the next search over the table entries in use
            lo    <= '0;
            hi    <= twon_m1;
            mid   <= crsq_pkg::idx_t'(n);
            phase <= phase_next;
            state <= (phase == PH_BMAX) ? S_CALC : S_ISSUE;
          end
        end
        S_CALC: begin
          inj_tok <= q_tok;
          pres    <= pres_c;
          nxt     <= next_c;
          prv     <= prev_c;
          state   <= S_CHAIN;
        end
        S_CHAIN: begin
          if (ch_vld && ch_tok.is_q) begin
            done_tok <= ch_tok;
            state    <= S_DONE;
          end
        end
        S_DONE: begin
          if (!result.valid || result.ready) begin
            result.present        <= pres;
            result.next_char      <= nxt;
            result.prev_char      <= prv;
            result.rank_found     <= done_tok.rfound;
            result.rank_of_char   <= done_tok.rank;
            result.char_at_rank   <= done_tok.at;
            result.count_in_range <= crsq_pkg::sat_code(done_tok.cacc);
            result.total_count    <= crsq_pkg::sat_code(done_tok.total);
            state                 <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
